// ===== design/skp_pkg.sv =====
`timescale 1ns / 1ps

package skp_pkg;

  // Item kinds on the entry channel
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_MUL   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

  localparam int DIM_W = 17;
  localparam int TOL_W = 63;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } skp_state_t;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic load;
    logic shift;
  } skp_cell_ctrl_t;

  // One product token handed to the emit stage
  typedef struct packed {
    logic               valid;
    logic               fin;
    logic [31:0]        row;
    logic [31:0]        col;
    logic signed [63:0] value;
  } skp_tok_t;

endpackage

// ===== design/skp_if.sv =====
`timescale 1ns / 1ps

interface skp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        entry_row;
  logic [15:0]        entry_col;
  logic signed [31:0] entry_value;

  modport source(output valid, kind, entry_row, entry_col, entry_value, input ready);
  modport sink(input valid, kind, entry_row, entry_col, entry_value, output ready);
endinterface

interface skp_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        out_row;
  logic [31:0]        out_col;
  logic signed [63:0] out_value;
  logic               last;

  modport source(output valid, out_row, out_col, out_value, last, input ready);
  modport sink(input valid, out_row, out_col, out_value, last, output ready);
endinterface

// ===== design/sparse_kronecker_product.sv =====
`timescale 1ns / 1ps

// Sparse Kronecker product engine.
// Channel "entry" carries items: load a B entry, multiply an A entry, or
// clear the B store. Channel "result" carries product entries with a last
// mark on the final one caused by an A entry. The cfg_* write port sets
// b_rows, b_cols and tolerance; the user must write it only while the block
// is idle, which the block itself does not enforce. An A entry passes a
// setup state (index base multiply and magnitude check), then, if it passes
// the check, a run state that steps through each stored B entry and then the
// end token; no new item is taken until the block is idle again. B entries
// live in a ring of cells that rotates once per A entry; the head cell feeds
// one 32x32 multiplier, so one product per cycle while the receiver does not
// stall. A product passes the multiply stage and the pending slot, where it
// waits for the next passing product or the end of the run, since last is
// only known then. Reset clears the configuration to b_rows = b_cols = 1,
// tolerance = 0, and empties the store. When the receiver stalls, the ring,
// the multiplier stage and the pending slot all hold; nothing is dropped.
module sparse_kronecker_product
  import skp_pkg::*;
#(
  parameter int B_CAPACITY = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  skp_in_if.sink                entry,
  skp_out_if.source             result
);

  localparam int IDX_W = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam int CNT_W = $clog2(B_CAPACITY + 1);
  localparam int BASE_W = IDX_W + DIM_W;

  // Configuration
  logic [DIM_W-1:0] b_rows;
  logic [DIM_W-1:0] b_cols;
  logic [TOL_W-1:0] tolerance;

  // Control state
  skp_state_t       state;
  skp_state_t       state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] step;

  // A entry under work
  logic [IDX_W-1:0]   a_row;
  logic [IDX_W-1:0]   a_col;
  logic signed [31:0] a_value;
  logic [31:0]        base_row;
  logic [31:0]        base_col;

  logic               accept;
  logic               a_pass;
  logic [31:0]        a_mag;
  logic [BASE_W-1:0]  base_row_full;
  logic [BASE_W-1:0]  base_col_full;
  logic               run_end;
  logic               adv;
  skp_cell_ctrl_t     ctl;
  skp_tok_t           tok;

  logic [IDX_W-1:0]   c_row   [B_CAPACITY];
  logic [IDX_W-1:0]   c_col   [B_CAPACITY];
  logic signed [31:0] c_value [B_CAPACITY];

  assign accept  = entry.valid && entry.ready;
  assign run_end = (step == count);

  // Config writes: index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      b_rows    <= DIM_W'(1);
      b_cols    <= DIM_W'(1);
      tolerance <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_B_ROWS:    b_rows    <= cfg_data[DIM_W-1:0];
        CFG_B_COLS:    b_cols    <= cfg_data[DIM_W-1:0];
        CFG_TOLERANCE: tolerance <= cfg_data[TOL_W-1:0];
        default:       ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && entry.kind == KIND_MUL) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = a_pass ? ST_RUN : ST_IDLE;
      end
      ST_RUN: begin
        if (adv && run_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    entry.ready = 1'b0;
    ctl.load    = 1'b0;
    ctl.shift   = 1'b0;
    case (state)
      ST_IDLE: begin
        entry.ready = 1'b1;
        ctl.load    = entry.valid && entry.kind == KIND_LOAD;
      end
      ST_RUN: begin
        ctl.shift = adv && !run_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      // Append loads until full; clear only drops the fill count
      if (accept && entry.kind == KIND_LOAD && count != CNT_W'(B_CAPACITY)) begin
        count <= count + CNT_W'(1);
      end else if (accept && entry.kind == KIND_CLEAR) begin
        count <= '0;
      end
      if (state == ST_SETUP) begin
        step <= '0;
      end else if (ctl.shift) begin
        step <= step + CNT_W'(1);
      end
    end
  end

  // Capture the A entry; indices wrap to the index width
  always_ff @(posedge clk) begin
    if (accept && entry.kind == KIND_MUL) begin
      a_row   <= entry.entry_row[IDX_W-1:0];
      a_col   <= entry.entry_col[IDX_W-1:0];
      a_value <= entry.entry_value;
    end
  end

  // Setup: base indices and the A magnitude check (Q16.16 scaled to Q32.32)
  assign a_mag         = a_value[31] ? 32'(-a_value) : 32'(a_value);
  assign a_pass        = TOL_W'({a_mag, 16'b0}) > tolerance;
  assign base_row_full = BASE_W'(a_row) * BASE_W'(b_rows);
  assign base_col_full = BASE_W'(a_col) * BASE_W'(b_cols);

  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      base_row <= 32'(base_row_full);
      base_col <= 32'(base_col_full);
    end
  end

  // Ring of B cells: each takes from its right neighbor, the last occupied
  // cell takes the head, so a full rotation restores load order.
  for (genvar g = 0; g < B_CAPACITY; g++) begin : g_cell
    localparam int NXT = (g + 1 < B_CAPACITY) ? g + 1 : 0;
    skp_cell #(
      .IDX  (g),
      .CNT_W(CNT_W),
      .IDX_W(IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .load_row  (entry.entry_row[IDX_W-1:0]),
      .load_col  (entry.entry_col[IDX_W-1:0]),
      .load_value(entry.entry_value),
      .next_row  (c_row[NXT]),
      .next_col  (c_col[NXT]),
      .next_value(c_value[NXT]),
      .head_row  (c_row[0]),
      .head_col  (c_col[0]),
      .head_value(c_value[0]),
      .row       (c_row[g]),
      .col       (c_col[g]),
      .value     (c_value[g])
    );
  end

  // Multiply stage: one product of the head entry per cycle while the emit
  // stage lets it advance, then an end token once every stored entry has passed.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (adv) begin
      tok.valid <= (state == ST_RUN);
    end
    if (adv) begin
      tok.fin   <= run_end;
      tok.row   <= base_row + 32'(c_row[0]);
      tok.col   <= base_col + 32'(c_col[0]);
      tok.value <= $signed(a_value) * $signed(c_value[0]);
    end
  end

  skp_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .tok      (tok),
    .tolerance(tolerance),
    .adv      (adv),
    .result   (result)
  );

  // Fill count never passes capacity
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(B_CAPACITY))
    else $error("store fill count beyond capacity");

  // Rotation never runs past the occupied cells
  assert property (@(posedge clk) disable iff (rst) (state == ST_RUN) |-> (step <= count))
    else $error("ring step beyond fill count");

  // A run that finishes is followed by an end token and a return to idle
  assert property (@(posedge clk) disable iff (rst)
    (adv && state == ST_RUN && run_end) |=> (tok.valid && tok.fin && state == ST_IDLE))
    else $error("end token missing after run");

endmodule

// ===== design/skp_cell.sv =====
`timescale 1ns / 1ps

module skp_cell
  import skp_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7,
  parameter int IDX_W = 16
) (
  input  logic               clk,
  input  skp_cell_ctrl_t     ctl,
  input  logic [CNT_W-1:0]   count,
  input  logic [IDX_W-1:0]   load_row,
  input  logic [IDX_W-1:0]   load_col,
  input  logic signed [31:0] load_value,
  input  logic [IDX_W-1:0]   next_row,
  input  logic [IDX_W-1:0]   next_col,
  input  logic signed [31:0] next_value,
  input  logic [IDX_W-1:0]   head_row,
  input  logic [IDX_W-1:0]   head_col,
  input  logic signed [31:0] head_value,
  output logic [IDX_W-1:0]   row,
  output logic [IDX_W-1:0]   col,
  output logic signed [31:0] value
);

  logic at_tail;
  logic at_load;

  assign at_load = (count == CNT_W'(IDX));
  // The last occupied cell closes the ring by taking the head entry
  assign at_tail = (count == CNT_W'(IDX + 1));

  always_ff @(posedge clk) begin
    if (ctl.load && at_load) begin
      row   <= load_row;
      col   <= load_col;
      value <= load_value;
    end else if (ctl.shift) begin
      if (at_tail) begin
        row   <= head_row;
        col   <= head_col;
        value <= head_value;
      end else begin
        row   <= next_row;
        col   <= next_col;
        value <= next_value;
      end
    end
  end

endmodule

// ===== design/skp_emit.sv =====
`timescale 1ns / 1ps

module skp_emit
  import skp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  skp_tok_t         tok,
  input  logic [TOL_W-1:0] tolerance,
  output logic             adv,
  skp_out_if.source        result
);

  logic [63:0]        mag;
  logic               pass;
  logic               push_data;
  logic               push_end;
  logic               pend_valid;
  logic [31:0]        pend_row;
  logic [31:0]        pend_col;
  logic signed [63:0] pend_value;

  assign mag       = tok.value[63] ? 64'(-tok.value) : 64'(tok.value);
  assign pass      = mag > {1'b0, tolerance};
  assign push_data = tok.valid && !tok.fin && pass;
  assign push_end  = tok.valid && tok.fin && pend_valid;
  assign adv       = !result.valid || result.ready;

  // A passing product waits in the pending slot until the next passing
  // product or the end token tells whether it is the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (adv) begin
      result.valid <= (push_data && pend_valid) || push_end;
      if (push_data) begin
        pend_valid <= 1'b1;
      end else if (tok.valid && tok.fin) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if ((push_data && pend_valid) || push_end) begin
        result.out_row   <= pend_row;
        result.out_col   <= pend_col;
        result.out_value <= pend_value;
        result.last      <= push_end;
      end
      if (push_data) begin
        pend_row   <= tok.row;
        pend_col   <= tok.col;
        pend_value <= tok.value;
      end
    end
  end

endmodule

// ===== sim/skp_product_checker.sv =====
`timescale 1ns / 1ps

module skp_product_checker
  import skp_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  skp_in_if                     entry,
  skp_out_if                    result,
  output int                    outstanding,
  output int                    mismatches
);

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [31:0]        row;
    logic [31:0]        col;
    logic signed [63:0] value;
    logic               last;
  } kron_entry_t;

  // Shadow copy of the block's configuration and B store
  logic [DIM_W-1:0]   dim_rows;
  logic [DIM_W-1:0]   dim_cols;
  logic [TOL_W-1:0]   tol_q32;
  logic [15:0]        b_row_mem [STORE_DEPTH];
  logic [15:0]        b_col_mem [STORE_DEPTH];
  logic signed [31:0] b_value_mem [STORE_DEPTH];
  logic [6:0]         b_count;

  kron_entry_t expected_products[$];
  int          pending_cnt = 0;
  int          error_total = 0;

  assign outstanding = pending_cnt;
  assign mismatches  = error_total;

  task automatic flag_mismatch(string msg);
    // print the first hundred, count them all
    if (error_total < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    error_total++;
  endtask

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  task automatic predict_kron_products(logic [1:0] kind, logic [15:0] row, logic [15:0] col,
                                       logic signed [31:0] value);
    logic [63:0] base_row;
    logic [63:0] base_col;
    logic [63:0] a_mag;
    longint      prod;
    kron_entry_t item;
    int          first;
    case (kind)
      KIND_LOAD: begin
        if (b_count < STORE_DEPTH) begin
          b_row_mem[b_count]   = row;
          b_col_mem[b_count]   = col;
          b_value_mem[b_count] = value;
          b_count++;
        end
      end
      KIND_CLEAR: begin
        b_count = '0;
      end
      KIND_MUL: begin
        a_mag = magnitude(longint'(value)) << 16;
        if (a_mag > 64'(tol_q32)) begin
          base_row = 64'(row) * 64'(dim_rows);
          base_col = 64'(col) * 64'(dim_cols);
          first    = expected_products.size();
          for (int i = 0; i < b_count; i++) begin
            prod = longint'(value) * longint'(b_value_mem[i]);
            if (magnitude(prod) > 64'(tol_q32)) begin
              item.row   = 32'(base_row + 64'(b_row_mem[i]));
              item.col   = 32'(base_col + 64'(b_col_mem[i]));
              item.value = prod;
              item.last  = 1'b0;
              expected_products.push_back(item);
            end
          end
          if (expected_products.size() > first) begin
            expected_products[expected_products.size() - 1].last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_product();
    kron_entry_t want;
    if (expected_products.size() == 0) begin
      flag_mismatch($sformatf("unexpected product row %0d col %0d value %0d last %0b",
                              result.out_row, result.out_col, result.out_value, result.last));
      return;
    end
    want = expected_products.pop_front();
    if (result.out_row !== want.row) begin
      flag_mismatch($sformatf("out_row %0d, want %0d", result.out_row, want.row));
    end
    if (result.out_col !== want.col) begin
      flag_mismatch($sformatf("out_col %0d, want %0d", result.out_col, want.col));
    end
    if (result.out_value !== want.value) begin
      flag_mismatch($sformatf("out_value %0d, want %0d", result.out_value, want.value));
    end
    if (result.last !== want.last) begin
      flag_mismatch($sformatf("last %0b, want %0b (row %0d col %0d)", result.last, want.last,
                              want.row, want.col));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dim_rows = DIM_W'(1);
      dim_cols = DIM_W'(1);
      tol_q32  = '0;
      b_count  = '0;
      expected_products.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_B_ROWS:    dim_rows = cfg_data[DIM_W-1:0];
          CFG_B_COLS:    dim_cols = cfg_data[DIM_W-1:0];
          CFG_TOLERANCE: tol_q32 = cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      // products leaving now were caused by earlier items, so retire them first
      if (result.valid && result.ready) begin
        check_product();
      end
      if (entry.valid && entry.ready) begin
        predict_kron_products(entry.kind, entry.entry_row, entry.entry_col, entry.entry_value);
      end
    end
    pending_cnt <= expected_products.size();
  end

endmodule

// ===== sim/sparse_kronecker_product_tb.sv =====
`timescale 1ns / 1ps

// Drives the sparse Kronecker product engine with a short directed sequence
// and then phases of random load / multiply / clear bursts, each phase under
// its own configuration and one of four idle patterns. The checker beside
// the DUT predicts every product and reports back a mismatch count.
module sparse_kronecker_product_tb;
  import skp_pkg::*;

  localparam int          DRAIN_CYCLES = 100;   // longer than one full A walk
  localparam int          STALL_LIMIT  = 2000;  // quiet cycles before giving up
  localparam int          PHASE_ITEMS  = 68;
  localparam int          NUM_PHASES   = 6;
  localparam logic [1:0]  KIND_SPARE   = 2'd3;  // unused kind, must be ignored
  localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
  localparam logic [TOL_W-1:0] TOL_ONE = TOL_W'(64'h1_0000_0000);
  localparam logic [TOL_W-1:0] TOL_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_accepted = 0;
  int quiet_cycles   = 0;
  int outstanding;
  int mismatches;

  skp_in_if  entry();
  skp_out_if result();

  sparse_kronecker_product DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .entry     (entry),
    .result    (result)
  );

  skp_product_checker product_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .entry       (entry),
    .result      (result),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #1 clk = ~clk;

  // Receiver: drop ready on a random share of cycles
  always @(posedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run if no transaction moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (entry.valid && entry.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one item, idling first at the phase's rate, and hold it until taken
  task automatic send_item(logic [1:0] kind, logic [15:0] row, logic [15:0] col,
                           logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      entry.valid <= 1'b0;
      @(posedge clk);
    end
    entry.valid       <= 1'b1;
    entry.kind        <= kind;
    entry.entry_row   <= row;
    entry.entry_col   <= col;
    entry.entry_value <= value;
    @(posedge clk);
    while (!entry.ready) @(posedge clk);
    items_accepted++;
  endtask

  // Hold the sender until every predicted product has arrived, then let the
  // block finish any A walk whose products were all filtered out
  task automatic quiesce();
    entry.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on back-to-back edges; only call when idle
  task automatic write_config(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                              logic [TOL_W-1:0] tol);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_B_ROWS;
    cfg_data  <= CFG_DATA_W'(rows);
    @(posedge clk);
    cfg_index <= CFG_B_COLS;
    cfg_data  <= CFG_DATA_W'(cols);
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_data  <= CFG_DATA_W'(tol);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Favor the Q16.16 corner values, small magnitudes and plain random words
  function automatic logic [31:0] rand_value();
    logic [31:0] small_val;
    small_val = $urandom_range(255);
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return ONE_Q16;
      4: return -ONE_Q16;
      5: return $urandom_range(1) ? -small_val : small_val;
      default: return $urandom;
    endcase
  endfunction

  // Small indices make duplicate positions likely; the ends are hit often
  function automatic logic [15:0] rand_index();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed bursts: optional clear, a batch of B loads (now and
  // then enough to overflow the store), then a few A entries. The rest is
  // noise with any kind, including the unused one.
  task automatic run_burst();
    int n_load;
    int n_mul;
    if ($urandom_range(99) < 85) begin
      if ($urandom_range(99) < 70) begin
        send_item(KIND_CLEAR, rand_index(), rand_index(), $urandom);
      end
      n_load = ($urandom_range(15) == 0) ? $urandom_range(70, 56) : $urandom_range(6, 0);
      n_mul  = $urandom_range(4, 1);
      repeat (n_load) send_item(KIND_LOAD, rand_index(), rand_index(), rand_value());
      repeat (n_mul) send_item(KIND_MUL, rand_index(), rand_index(), rand_value());
    end else begin
      repeat ($urandom_range(4, 1)) begin
        send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    int phase_start;

    // Known values on every input from time zero
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_B_ROWS;
    cfg_data          <= '0;
    entry.valid       <= 1'b0;
    entry.kind        <= KIND_LOAD;
    entry.entry_row   <= '0;
    entry.entry_col   <= '0;
    entry.entry_value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset configuration (1 x 1, tolerance zero), no idling
    send_item(KIND_MUL, 16'd7, 16'd9, ONE_Q16);              // empty store: nothing
    send_item(KIND_LOAD, 16'd0, 16'd0, ONE_Q16);
    send_item(KIND_LOAD, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(KIND_LOAD, 16'd1, 16'd2, 32'h8000_0000);
    send_item(KIND_LOAD, 16'd3, 16'd4, 32'h0);               // zero product is filtered
    send_item(KIND_LOAD, 16'd0, 16'd0, 32'hFFFF_FFFF);       // duplicate position
    send_item(KIND_MUL, 16'd0, 16'd0, ONE_Q16);
    send_item(KIND_MUL, 16'hFFFF, 16'hFFFF, 32'h8000_0000);  // most negative squared
    send_item(KIND_MUL, 16'd5, 16'd5, 32'h0);                // A value too small
    send_item(KIND_SPARE, 16'hA5A5, 16'h5A5A, 32'hDEAD_BEEF);
    send_item(KIND_MUL, 16'd1, 16'd1, 32'h7FFF_FFFF);
    send_item(KIND_CLEAR, 16'd0, 16'd0, 32'h0);
    send_item(KIND_MUL, 16'd2, 16'd2, ONE_Q16);              // cleared store: nothing
    send_item(KIND_LOAD, 16'd9, 16'd8, -ONE_Q16);
    send_item(KIND_MUL, 16'd4, 16'd4, -ONE_Q16);

    // Largest tolerance filters every A entry
    quiesce();
    write_config(DIM_W'(65536), DIM_W'(65536), TOL_MAX);
    send_item(KIND_MUL, 16'hFFFF, 16'hFFFF, 32'h8000_0000);

    // Oversized rows wrap the output row; zero columns collapse the output column to b_col
    quiesce();
    write_config('1, '0, '0);
    send_item(KIND_LOAD, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(KIND_MUL, 16'hFFFF, 16'hFFFF, ONE_Q16);

    // Tolerance of exactly 1.0: an A value of 1.0 must not pass, one ulp more does
    quiesce();
    write_config(DIM_W'(65536), DIM_W'(65536), TOL_ONE);
    send_item(KIND_MUL, 16'hFFFF, 16'hFFFF, ONE_Q16);
    send_item(KIND_MUL, 16'hFFFF, 16'h0000, ONE_Q16 + 32'd1);
    send_item(KIND_MUL, 16'h0000, 16'hFFFF, -ONE_Q16 - 32'd1);

    // Random phases, each under its own setting and one of four idle patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiesce();
      case (ph)
        0: write_config(DIM_W'(1), DIM_W'(1), '0);
        1: write_config(DIM_W'(65536), DIM_W'(65536), TOL_ONE);
        2: write_config(DIM_W'($urandom_range(65536, 1)), DIM_W'($urandom_range(65536, 1)),
                        TOL_W'({$urandom, $urandom} >> $urandom_range(62, 20)));
        3: write_config(DIM_W'(2), DIM_W'(65535), '0);
        4: write_config(DIM_W'(65536), DIM_W'(1),
                        TOL_W'({$urandom, $urandom} >> $urandom_range(62, 16)));
        default: write_config(DIM_W'($urandom_range(65536, 1)),
                              DIM_W'($urandom_range(65536, 1)), TOL_W'(16'hFFFF));
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      phase_start = items_accepted;
      while (items_accepted - phase_start < PHASE_ITEMS) run_burst();
    end

    // Drain everything still in flight, then give the verdict
    quiesce();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
